// ===== design/lze_pkg.sv =====
// Shared constants and controller/datapath command and status types
// for the LZ77 token encoder. No dependencies.
`default_nettype none
package lze_pkg;
  localparam int WINDOW_MAX = 1024;
  localparam int MAX_MATCH  = 255;
  localparam int HIST_AW    = $clog2(WINDOW_MAX);
  localparam int DIST_W     = 11;
  localparam int LEN_W      = 8;
  localparam int BYTE_W     = 8;
  localparam int PADDR_W    = 3;

  localparam logic [DIST_W-1:0] WIN_RESET = DIST_W'(1024);

  typedef struct packed {
    logic start;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic last_issue;
    logic emit;
    logic out_busy;
  } status_t;
endpackage
`default_nettype wire

// ===== design/lze_if.sv =====
// Valid/ready stream interfaces for bytes in and tokens out.
// Depends on lze_pkg.
`default_nettype none
interface lze_byte_if;
  logic                        valid;
  logic                        ready;
  logic [lze_pkg::BYTE_W-1:0]  pixel;
  logic                        in_last;
  modport source (output valid, pixel, in_last, input ready);
  modport sink   (input valid, pixel, in_last, output ready);
endinterface

interface lze_tok_if;
  logic                        valid;
  logic                        ready;
  logic [lze_pkg::DIST_W-1:0]  offset;
  logic [lze_pkg::LEN_W-1:0]   match_len;
  logic [lze_pkg::BYTE_W-1:0]  next_byte;
  logic                        out_last;
  modport source (output valid, offset, match_len, next_byte, out_last, input ready);
  modport sink   (input valid, offset, match_len, next_byte, out_last, output ready);
endinterface
`default_nettype wire

// ===== design/lz77_token_encoder.sv =====
// LZ77 token encoder top: APB window register, sequencer, datapath.
// Per item: accept, then a window sweep over L distances, L the phrase's search limit (min of
// window, bytes seen), reading one history entry per cycle, then drain and finish. Items with
// nothing to search (empty window at phrase start, match saturated or on last byte) go to finish.
// One item in flight; at most one token per item, held in an output register, which stalls.
// Reset (async, active low) clears control state; the window register resets to 1024.
`default_nettype none
module lz77_token_encoder (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  lze_byte_if.sink                          in_if,
  lze_tok_if.source                         out_if,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lze_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output      logic [31:0]                  prdata,
  output      logic                         pready
);
  logic [lze_pkg::DIST_W-1:0] win_q;
  lze_pkg::cmd_t    cmd;
  lze_pkg::status_t status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(win_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= lze_pkg::WIN_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      win_q <= pwdata[lze_pkg::DIST_W-1:0];
    end
  end

  lze_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .status_i(status), .cmd_o(cmd)
  );

  lze_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status), .win_i(win_q),
    .pixel_i(in_if.pixel), .in_last_i(in_if.in_last),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .offset_o(out_if.offset), .match_len_o(out_if.match_len),
    .next_byte_o(out_if.next_byte), .out_last_o(out_if.out_last)
  );
endmodule
`default_nettype wire

// ===== design/lze_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lze_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== design/lze_ctrl.sv =====
// Sequencer: accept, window sweep, drain, finish.
// Depends on lze_pkg.
`default_nettype none
module lze_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire lze_pkg::status_t status_i,
  output      lze_pkg::cmd_t    cmd_o
);
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SWEEP  = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_d, state_q;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d = status_i.skip ? S_FINISH : S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd_o.issue = 1'b1;
        if (status_i.last_issue) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = S_FINISH;
      S_FINISH: begin
        if (!(status_i.emit && status_i.out_busy)) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end
endmodule
`default_nettype wire

// ===== design/lze_dp.sv =====
// Datapath: history and candidate RAMs, compare, token register.
// Depends on lze_pkg and lze_ram.
`default_nettype none
module lze_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lze_pkg::cmd_t                 cmd_i,
  output      lze_pkg::status_t              status_o,
  input  wire logic [lze_pkg::DIST_W-1:0]    win_i,
  input  wire logic [lze_pkg::BYTE_W-1:0]    pixel_i,
  input  wire logic                          in_last_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [lze_pkg::DIST_W-1:0]    offset_o,
  output      logic [lze_pkg::LEN_W-1:0]     match_len_o,
  output      logic [lze_pkg::BYTE_W-1:0]    next_byte_o,
  output      logic                          out_last_o
);
  localparam int AW = lze_pkg::HIST_AW;
  localparam int DW = lze_pkg::DIST_W;
  localparam int LW = lze_pkg::LEN_W;
  localparam int BW = lze_pkg::BYTE_W;
  localparam logic [DW-1:0] WMAX = DW'(lze_pkg::WINDOW_MAX);
  localparam logic [LW-1:0] MMAX = LW'(lze_pkg::MAX_MATCH);

  logic [BW-1:0] x_q;
  logic          last_q, cont_q, skip_q, any_q, pv_q;
  logic [DW-1:0] lim_q, d_q, pd_q, nb_q, best_q, seen_q;
  logic [LW-1:0] len_q;
  logic [AW-1:0] wr_q;
  logic          ov_q;

  logic [DW-1:0] wclip, eff;
  logic [BW-1:0] hist_rd;
  logic          alive_rd, hit, alive_new, emit;
  logic [DW-1:0] dm1, pdm1;

  assign wclip = (win_i > WMAX) ? WMAX : win_i;
  assign eff   = (wclip > seen_q) ? seen_q : wclip;
  assign dm1   = d_q - DW'(1);
  assign pdm1  = pd_q - DW'(1);

  lze_ram #(.WIDTH(BW), .DEPTH(lze_pkg::WINDOW_MAX)) u_hist (
    .clk_i, .we_i(cmd_i.finish), .waddr_i(wr_q), .wdata_i(x_q),
    .raddr_i(wr_q - d_q[AW-1:0]), .rdata_o(hist_rd)
  );

  assign hit       = (hist_rd == x_q);
  assign alive_new = (cont_q ? alive_rd : 1'b1) & hit;

  lze_ram #(.WIDTH(1), .DEPTH(lze_pkg::WINDOW_MAX)) u_alive (
    .clk_i, .we_i(pv_q), .waddr_i(pdm1[AW-1:0]), .wdata_i(alive_new),
    .raddr_i(dm1[AW-1:0]), .rdata_o(alive_rd)
  );

  assign emit = cont_q ? (skip_q || !any_q) : !(any_q && !last_q);

  always_comb begin
    status_o.skip       = (len_q == '0) ? (eff == '0)
                                        : ((len_q >= MMAX) || in_last_i);
    status_o.last_issue = (d_q == lim_q);
    status_o.emit       = emit;
    status_o.out_busy   = ov_q && !out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q    <= pixel_i;
      last_q <= in_last_i;
      cont_q <= (len_q != '0);
      skip_q <= status_o.skip;
      d_q    <= DW'(1);
      if (len_q == '0) lim_q <= eff;
    end else if (cmd_i.issue) begin
      d_q <= d_q + DW'(1);
    end
    pd_q <= d_q;
    if (cmd_i.start) begin
      any_q <= 1'b0;
      nb_q  <= '0;
    end else if (pv_q && alive_new) begin
      any_q <= 1'b1;
      nb_q  <= pd_q;
    end
    if (cmd_i.finish && emit) begin
      offset_o    <= cont_q ? best_q : '0;
      match_len_o <= cont_q ? len_q : '0;
      next_byte_o <= x_q;
      out_last_o  <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= 1'b0;
      len_q  <= '0;
      best_q <= '0;
      seen_q <= '0;
      wr_q   <= '0;
      ov_q   <= 1'b0;
    end else begin
      pv_q <= cmd_i.issue;
      if (cmd_i.finish && emit) ov_q <= 1'b1;
      else if (out_ready_i)     ov_q <= 1'b0;
      if (cmd_i.finish) begin
        if (emit) begin
          len_q <= '0;
        end else begin
          len_q  <= len_q + LW'(1);
          best_q <= nb_q;
        end
        wr_q <= wr_q + AW'(1);
        if (last_q)          seen_q <= '0;
        else if (seen_q < WMAX) seen_q <= seen_q + DW'(1);
      end
    end
  end

  assign out_valid_o = ov_q;
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for lz77_token_encoder: streams bytes, predicts LZ77 tokens,
// and checks every emitted token in order. Depends on lze_pkg, lze_if and the encoder RTL.
`timescale 1ns / 1ps
module testbench;
  import lze_pkg::*;

  localparam int LIMIT = 20000;
  localparam int SETTLE = WINDOW_MAX + 80;
  localparam logic [PADDR_W-1:0] WINDOW_ADDR = PADDR_W'(0);

  typedef struct packed {
    logic [DIST_W-1:0] off;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] lit;
    logic              last;
  } token_t;

  typedef struct {
    logic [BYTE_W-1:0] px;
    logic              lst;
    bit                typed;
    token_t            tok;
  } byte_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  wire  [31:0] prdata;
  wire         pready;

  lze_byte_if in_if ();
  lze_tok_if  out_if ();

  lz77_token_encoder i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2ns clk_i = ~clk_i;

  // encoder model state
  logic [BYTE_W-1:0]   hist [WINDOW_MAX];
  bit   [WINDOW_MAX:0] alive;
  int                  cur_len, seen, wr_ptr;
  logic [DIST_W-1:0]   win;

  token_t exp_tokens[$];
  int     errors = 0;
  bit     calm = 1'b0;
  int     stall_left = 0;
  int     idle_cycles = 0;

  // stream generator state
  int stream_left = 0;
  int stream_mode = 0;
  logic [BYTE_W-1:0] pattern [4];

  task automatic report(input string what, input int got, input int want);
    $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic encode_byte(input logic [BYTE_W-1:0] x, input logic lst,
                             output bit emitted, output token_t t);
    int eff, best;
    bit any;
    emitted = 1'b0;
    t = '0;
    if (cur_len == 0) begin
      eff = (int'(win) > WINDOW_MAX) ? WINDOW_MAX : int'(win);
      if (eff > seen) eff = seen;
      any = 1'b0;
      for (int d = 1; d <= WINDOW_MAX; d++) begin
        alive[d] = (d <= eff) && (hist[(wr_ptr + WINDOW_MAX - d) % WINDOW_MAX] == x);
        any |= alive[d];
      end
      if (any && !lst) begin
        cur_len = 1;
      end else begin
        alive = '0;
        t = '{off: '0, len: '0, lit: x, last: lst};
        emitted = 1'b1;
      end
    end else begin
      best = 0;
      for (int d = 1; d <= WINDOW_MAX; d++) if (alive[d]) best = d;
      if (cur_len >= MAX_MATCH || lst) begin
        t = '{off: DIST_W'(best), len: LEN_W'(cur_len), lit: x, last: lst};
        emitted = 1'b1;
        cur_len = 0;
        alive = '0;
      end else begin
        any = 1'b0;
        for (int d = 1; d <= WINDOW_MAX; d++) begin
          if (alive[d]) begin
            if (hist[(wr_ptr + WINDOW_MAX - d) % WINDOW_MAX] == x) any = 1'b1;
            else alive[d] = 1'b0;
          end
        end
        if (any) begin
          cur_len++;
        end else begin
          t = '{off: DIST_W'(best), len: LEN_W'(cur_len), lit: x, last: 1'b0};
          emitted = 1'b1;
          cur_len = 0;
          alive = '0;
        end
      end
    end
    hist[wr_ptr] = x;
    wr_ptr = (wr_ptr + 1) % WINDOW_MAX;
    if (seen < WINDOW_MAX) seen++;
    if (lst) begin
      seen = 0;
      cur_len = 0;
      alive = '0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // called right after a rising edge; returns right after the accepting edge
  task automatic push_byte(input logic [BYTE_W-1:0] x, input logic lst,
                           input bit typed, input token_t typed_tok);
    int gap;
    bit emitted;
    token_t t;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.pixel   <= x;
    in_if.in_last <= lst;
    do @(posedge clk_i); while (!in_if.ready);
    encode_byte(x, lst, emitted, t);
    if (typed) exp_tokens.push_back(typed_tok);
    else if (emitted) exp_tokens.push_back(t);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (exp_tokens.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == WINDOW_ADDR) win = data[DIST_W-1:0];
  endtask

  task automatic next_byte(output logic [BYTE_W-1:0] x, output logic lst);
    int r;
    if (stream_left == 0) begin
      r = $urandom_range(0, 99);
      stream_left = (r < 5) ? $urandom_range(61, 400) : $urandom_range(1, 60);
      r = $urandom_range(0, 99);
      stream_mode = (r < 55) ? 0 : (r < 80) ? 1 : 2;
      foreach (pattern[i]) pattern[i] = BYTE_W'($urandom);
    end
    case (stream_mode)
      0: x = 8'h61 + BYTE_W'($urandom_range(0, 3));
      1: x = pattern[$urandom_range(0, 1 + ($urandom_range(0, 3) == 0))];
      default: x = BYTE_W'($urandom);
    endcase
    lst = (stream_left == 1);
    stream_left--;
  endtask

  // output side: random stalls, in-order token check
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (exp_tokens.size() == 0) begin
          report("unexpected token offset", out_if.offset, 0);
        end else begin
          token_t e;
          e = exp_tokens.pop_front();
          if (out_if.offset !== e.off) report("offset", out_if.offset, e.off);
          if (out_if.match_len !== e.len) report("match_len", out_if.match_len, e.len);
          if (out_if.next_byte !== e.lit) report("next_byte", out_if.next_byte, e.lit);
          if (out_if.out_last !== e.last) report("out_last", out_if.out_last, e.last);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                   : $urandom_range(0, 2);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    byte_row_t rows[$];
    int windows[$];
    logic [BYTE_W-1:0] x;
    logic lst;
    int n_items;

    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_if.valid   <= 1'b0;
    in_if.pixel   <= '0;
    in_if.in_last <= 1'b0;
    hist   = '{default: '0};
    alive  = '0;
    cur_len = 0;
    seen   = 0;
    wr_ptr = 0;
    win    = WIN_RESET;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows = '{
      '{8'h00, 1'b0, 1'b1, '{11'd0, 8'd0, 8'h00, 1'b0}},
      '{8'hFF, 1'b1, 1'b1, '{11'd0, 8'd0, 8'hFF, 1'b1}},
      '{8'h61, 1'b0, 1'b1, '{11'd0, 8'd0, 8'h61, 1'b0}},
      '{8'h62, 1'b0, 1'b1, '{11'd0, 8'd0, 8'h62, 1'b0}},
      '{8'h61, 1'b0, 1'b0, '0},
      '{8'h62, 1'b0, 1'b0, '0},
      '{8'h61, 1'b0, 1'b0, '0},
      '{8'h62, 1'b0, 1'b0, '0},
      '{8'h63, 1'b0, 1'b0, '0},
      '{8'h61, 1'b0, 1'b0, '0},
      '{8'h61, 1'b0, 1'b0, '0},
      '{8'h61, 1'b0, 1'b0, '0},
      '{8'h61, 1'b0, 1'b0, '0},
      '{8'h61, 1'b1, 1'b0, '0},
      '{8'h80, 1'b1, 1'b1, '{11'd0, 8'd0, 8'h80, 1'b1}},
      '{8'h7F, 1'b0, 1'b1, '{11'd0, 8'd0, 8'h7F, 1'b0}},
      '{8'h7F, 1'b0, 1'b0, '0},
      '{8'h7F, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b0, '0}
    };
    calm = 1'b1;
    foreach (rows[i]) push_byte(rows[i].px, rows[i].lst, rows[i].typed, rows[i].tok);
    calm = 1'b0;

    // window settings; phases end mid-stream, so some changes land mid-phrase
    windows = '{1, 0, 2047, 2, 3, 5, 8, 16, 1024, 33, 100, 4, 255, 6};
    foreach (windows[p]) begin
      drain();
      apb_write(WINDOW_ADDR, 32'(windows[p]));
      calm = (p % 4 == 1);
      if (windows[p] == 1) begin
        // saturating match on a constant run
        for (int k = 0; k < 300; k++) push_byte(8'h55, k == 299, 1'b0, '0);
      end
      n_items = (windows[p] >= WINDOW_MAX) ? 40 : 125;
      for (int k = 0; k < n_items; k++) begin
        if (p == 3 && k == 60) begin
          in_if.valid <= 1'b0;
          do @(posedge clk_i); while (exp_tokens.size() != 0);
        end
        next_byte(x, lst);
        push_byte(x, lst, 1'b0, '0);
      end
    end

    drain();
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
